>>> design/assert_macros.svh
// Assertion macros shared by the ranger RTL.
// No dependencies; compiled ahead of the package and modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, switched off while reset is held.
`define USR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define USR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define USR_ASSERT(lbl, prop, msg)
`define USR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/usr_pkg.sv
// Types, constants and the segment decoder of the ultrasonic ranger.
// No dependencies; used by usr_out_if, usr_trig, usr_echo, usr_scan and the top level.
package usr_pkg;

  typedef logic [3:0] digit_t;

  localparam digit_t      DASH_CODE  = 4'd10;
  localparam logic [23:0] DIGIT_CAP  = 24'd1000;
  localparam logic [15:0] RST_PERIOD = 16'd800;
  localparam logic [7:0]  RST_WIDTH  = 8'd24;
  localparam logic [7:0]  RST_SCALE  = 8'd17;
  localparam logic [9:0]  RST_LIMIT  = 10'd400;
  localparam logic [7:0]  SEG_BLANK  = 8'hFF;
  localparam logic [7:0]  SEG_DP_MASK = 8'h7F;

  typedef enum logic [1:0] {
    CFG_TRIGGER_PERIOD = 2'd0,
    CFG_TRIGGER_WIDTH  = 2'd1,
    CFG_SCALE_PER_TICK = 2'd2,
    CFG_RANGE_LIMIT    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] trigger_period;
    logic [7:0]  trigger_width;
    logic [7:0]  scale_per_tick;
    logic [9:0]  range_limit;
  } cfg_t;

  typedef struct packed {
    logic   valid;
    digit_t hundreds;
    digit_t tens;
    digit_t units;
  } report_t;

  typedef struct packed {
    logic [7:0] segment;
    logic [3:0] select;
  } disp_t;

  // Active low seven-segment patterns; the dash code lights segment g only.
  function automatic logic [7:0] segment_for(digit_t code);
    logic [7:0] seg;
    unique case (code)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      4'd10:   seg = 8'hBF;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

>>> design/usr_in_if.sv
// Input channel of the ranger: valid/ready with the tick and echo sample.
// No dependencies.
interface usr_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic echo_level;

  modport source (output valid, output tick, output echo_level, input ready);
  modport sink   (input valid, input tick, input echo_level, output ready);
endinterface

>>> design/usr_out_if.sv
// Result channel of the ranger: valid/ready with trigger, display and report.
// Depends on usr_pkg for the digit type.
interface usr_out_if;
  logic              valid;
  logic              ready;
  logic              trigger_out;
  logic [7:0]        segment_out;
  logic [3:0]        digit_select;
  logic              report_valid;
  usr_pkg::digit_t   report_hundreds;
  usr_pkg::digit_t   report_tens;
  usr_pkg::digit_t   report_units;

  modport source (output valid, output trigger_out, output segment_out,
                  output digit_select, output report_valid, output report_hundreds,
                  output report_tens, output report_units, input ready);
  modport sink   (input valid, input trigger_out, input segment_out,
                  input digit_select, input report_valid, input report_hundreds,
                  input report_tens, input report_units, output ready);
endinterface

>>> design/usr_trig.sv
// Tick counter, trigger period counter and trigger pulse generator.
// Depends on usr_pkg for the configuration struct.
module usr_trig (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          tick,
  input  usr_pkg::cfg_t cfg,
  output logic [15:0]   free_tick,
  output logic          trigger_out
);

  logic [15:0] free_r, free_nxt;
  logic [15:0] period_r, period_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] period_inc;
  logic        fire;
  logic [7:0]  rem_now;

  always_comb begin
    period_inc = period_r + 16'd1;
    fire       = tick && (period_inc >= cfg.trigger_period);
    // A pulse that starts in this cycle is already high in this cycle.
    rem_now    = fire ? cfg.trigger_width : rem_r;
    free_nxt   = tick ? free_r + 16'd1 : free_r;
    period_nxt = tick ? (fire ? 16'd0 : period_inc) : period_r;
    rem_nxt    = (rem_now != 8'd0) ? rem_now - 8'd1 : 8'd0;
  end

  assign free_tick   = free_r;
  assign trigger_out = (rem_now != 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r   <= 16'd0;
      period_r <= 16'd0;
      rem_r    <= 8'd0;
    end else if (step) begin
      free_r   <= free_nxt;
      period_r <= period_nxt;
      rem_r    <= rem_nxt;
    end
  end

endmodule

>>> design/usr_echo.sv
// Echo edge detector, width times scale product and decimal digit split.
// Depends on usr_pkg for the configuration and report structs.
module usr_echo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             echo_level,
  input  logic [15:0]      free_tick,
  input  usr_pkg::cfg_t    cfg,
  output usr_pkg::report_t rpt
);

  logic            echo_prev_r;
  logic [15:0]     start_r, start_nxt;
  logic            rise, fall;
  logic [15:0]     width;
  logic [23:0]     range_cm;
  logic            over;
  logic [9:0]      range_lo;
  logic [9:0]      rem100;
  logic [6:0]      rem10;
  usr_pkg::digit_t hun, ten, uni;

  always_comb begin
    rise     = echo_level && !echo_prev_r;
    fall     = !echo_level && echo_prev_r;
    width    = free_tick - start_r;
    range_cm = {8'd0, width} * {16'd0, cfg.scale_per_tick};
    over     = (range_cm >= {14'd0, cfg.range_limit}) || (range_cm >= usr_pkg::DIGIT_CAP);
    range_lo = range_cm[9:0];

    // Digits by threshold compares; only meaningful when the value is below 1000.
    hun = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (range_lo >= 10'(k * 100)) hun = 4'(k);
    end
    rem100 = range_lo - 10'(hun) * 10'd100;
    ten = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem100[6:0] >= 7'(k * 10)) ten = 4'(k);
    end
    rem10 = rem100[6:0] - 7'(ten) * 7'd10;
    uni   = rem10[3:0];

    rpt.valid = fall;
    if (!fall) begin
      rpt.hundreds = 4'd0;
      rpt.tens     = 4'd0;
      rpt.units    = 4'd0;
    end else if (over) begin
      rpt.hundreds = usr_pkg::DASH_CODE;
      rpt.tens     = usr_pkg::DASH_CODE;
      rpt.units    = usr_pkg::DASH_CODE;
    end else begin
      rpt.hundreds = hun;
      rpt.tens     = ten;
      rpt.units    = uni;
    end

    priority if (rise) start_nxt = free_tick;
    else if (fall)     start_nxt = 16'd0;
    else               start_nxt = start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_prev_r <= 1'b0;
      start_r     <= 16'd0;
    end else if (step) begin
      echo_prev_r <= echo_level;
      start_r     <= start_nxt;
    end
  end

endmodule

>>> design/usr_scan.sv
// Display scan: position counter, stored digits and segment/select decode.
// Depends on usr_pkg for the report and display structs and the decoder.
module usr_scan #(
  parameter int SCAN_DIGITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             tick,
  input  usr_pkg::report_t rpt,
  output usr_pkg::disp_t   disp
);

  localparam int POS_W = (SCAN_DIGITS > 1) ? $clog2(SCAN_DIGITS) : 1;

  logic [POS_W-1:0] pos_r, pos_nxt;
  usr_pkg::digit_t  shown_r [3];
  logic [3:0]       pos_ext;
  usr_pkg::digit_t  code;
  logic             last;

  always_comb begin
    pos_ext = 4'(pos_r);
    // Only the three measured digits are stored; the rest show zero.
    code = (pos_ext < 4'd3) ? shown_r[pos_ext[1:0]] : 4'd0;
    disp.segment = usr_pkg::segment_for(code);
    if (pos_ext == 4'd0) disp.segment = disp.segment & usr_pkg::SEG_DP_MASK;
    disp.select = (pos_ext < 4'd4) ? ~(4'd1 << pos_ext[1:0]) : 4'hF;
    last    = (pos_ext == 4'(SCAN_DIGITS - 1));
    pos_nxt = last ? '0 : pos_r + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      shown_r[0] <= 4'd0;
      shown_r[1] <= 4'd0;
      shown_r[2] <= 4'd0;
    end else if (step) begin
      if (tick) pos_r <= pos_nxt;
      if (rpt.valid) begin
        shown_r[0] <= rpt.hundreds;
        shown_r[1] <= rpt.tens;
        shown_r[2] <= rpt.units;
      end
    end
  end

endmodule

>>> design/ultrasonic_ranger_with_led_scan.sv
// Top level of the ultrasonic ranger with multiplexed LED display.
// Depends on usr_pkg, usr_in_if, usr_out_if, usr_trig, usr_echo, usr_scan.
//
//   channel  direction  handshake      payload
//   in_ch    in         valid/ready    tick, echo_level
//   out_ch   out        valid/ready    trigger, segments, select, report digits
//   cfg_*    in         cfg_we only    cfg_index, cfg_data
//
// One item enters per cycle while the output is not stalled; each item passes the input
// register and then the result register before it is offered on out_ch.
// The input-to-result path is the 16x8 product and the decimal compares. Reset is
// synchronous and restores the valid flags, sub-block state and config to reset values.
// A stalled result holds; an empty input register still takes one more item.
`include "assert_macros.svh"
module ultrasonic_ranger_with_led_scan #(
  parameter int SCAN_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  usr_in_if.sink      in_ch,
  usr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  usr_pkg::cfg_t    cfg_r;
  logic             in_v_r, in_v_nxt;
  logic             in_tick_r, in_echo_r;
  logic             out_v_r, out_v_nxt;
  logic             adv, in_fire;
  logic [15:0]      free_tick;
  logic             trig;
  usr_pkg::report_t rpt;
  usr_pkg::disp_t   disp;
  logic             trig_r;
  usr_pkg::report_t rpt_r;
  usr_pkg::disp_t   disp_r;

  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : in_v_r);
    out_v_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_period <= usr_pkg::RST_PERIOD;
      cfg_r.trigger_width  <= usr_pkg::RST_WIDTH;
      cfg_r.scale_per_tick <= usr_pkg::RST_SCALE;
      cfg_r.range_limit    <= usr_pkg::RST_LIMIT;
    end else if (cfg_we) begin
      unique case (usr_pkg::cfg_idx_t'(cfg_index))
        usr_pkg::CFG_TRIGGER_PERIOD: cfg_r.trigger_period <= cfg_data;
        usr_pkg::CFG_TRIGGER_WIDTH:  cfg_r.trigger_width  <= cfg_data[7:0];
        usr_pkg::CFG_SCALE_PER_TICK: cfg_r.scale_per_tick <= cfg_data[7:0];
        usr_pkg::CFG_RANGE_LIMIT:    cfg_r.range_limit    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_tick_r <= in_ch.tick;
      in_echo_r <= in_ch.echo_level;
    end
    if (adv) begin
      trig_r <= trig;
      rpt_r  <= rpt;
      disp_r <= disp;
    end
  end

  usr_trig u_trig (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .tick        (in_tick_r),
    .cfg         (cfg_r),
    .free_tick   (free_tick),
    .trigger_out (trig)
  );

  usr_echo u_echo (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .echo_level (in_echo_r),
    .free_tick  (free_tick),
    .cfg        (cfg_r),
    .rpt        (rpt)
  );

  usr_scan #(.SCAN_DIGITS(SCAN_DIGITS)) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .tick  (in_tick_r),
    .rpt   (rpt),
    .disp  (disp)
  );

  assign out_ch.valid           = out_v_r;
  assign out_ch.trigger_out     = trig_r;
  assign out_ch.segment_out     = disp_r.segment;
  assign out_ch.digit_select    = disp_r.select;
  assign out_ch.report_valid    = rpt_r.valid;
  assign out_ch.report_hundreds = rpt_r.hundreds;
  assign out_ch.report_tens     = rpt_r.tens;
  assign out_ch.report_units    = rpt_r.units;

  `USR_ASSERT_ALWAYS(a_empty_after_reset, $past(!rst_n) |-> !out_v_r, "result valid after reset")
  `USR_ASSERT(a_ready_when_drained, !out_v_r |-> in_ch.ready, "input stalled with empty output")
  `USR_ASSERT(a_select_one_cold, out_v_r |-> $onehot0(~disp_r.select), "more than one digit driven")
  `USR_ASSERT(a_report_quiet, (out_v_r && !rpt_r.valid) |-> ({rpt_r.hundreds, rpt_r.tens, rpt_r.units} == 12'd0), "digits without a measurement")

endmodule
